@@ rtl/core/dsd_pkg.sv @@
// Shared types, constants and segment table for the digit sequencer.
package dsd_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned NUM_W = 14;
    localparam logic [15:0] NUM_MAX = 16'd9999;
    localparam logic [9:0]  AXIS_MAX = 10'd99;

    // floor(n / 10) == (n * DIV10_RECIP) >> DIV10_SHIFT for every n up to 9999
    localparam logic [12:0] DIV10_RECIP = 13'd6554;
    localparam int unsigned DIV10_SHIFT = 16;

    localparam logic [1:0] POS_THOUSANDS = 2'd0;
    localparam logic [1:0] POS_HUNDREDS  = 2'd1;
    localparam logic [1:0] POS_TENS      = 2'd2;
    localparam logic [1:0] POS_ONES      = 2'd3;

    typedef logic [NUM_W-1:0] num_t;

    // one run of digits: start at pos, step left until the number runs out or stop is reached
    typedef struct packed {
        logic       en;
        num_t       num;
        logic [1:0] pos;
        logic [1:0] stop;
    } run_t;

    typedef struct packed {
        run_t a;
        run_t b;
    } entry_t;

    function automatic logic [6:0] seg_of(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h67;
            default: seg = 7'h3F;
        endcase
        return seg;
    endfunction

endpackage

@@ rtl/core/dsd_front.sv @@
// Front end: classify a request into up to two digit runs.
module dsd_front
    import dsd_pkg::*;
(
    input  logic        cmd,
    input  logic [15:0] value,
    input  logic [9:0]  x_dev,
    input  logic [9:0]  y_dev,
    output entry_t      entry,
    output logic        lit
);

    always_comb
    begin
        if (cmd == 1'b0)
        begin
            entry.a.en   = (value <= NUM_MAX);
            entry.a.num  = value[NUM_W-1:0];
            entry.a.pos  = POS_ONES;
            entry.a.stop = POS_THOUSANDS;
            entry.b.en   = 1'b0;
            entry.b.num  = '0;
            entry.b.pos  = POS_ONES;
            entry.b.stop = POS_TENS;
        end
        else
        begin
            // x on positions 1 and 0, y on positions 3 and 2
            entry.a.en   = (x_dev <= AXIS_MAX);
            entry.a.num  = NUM_W'(x_dev);
            entry.a.pos  = POS_HUNDREDS;
            entry.a.stop = POS_THOUSANDS;
            entry.b.en   = (y_dev <= AXIS_MAX);
            entry.b.num  = NUM_W'(y_dev);
            entry.b.pos  = POS_ONES;
            entry.b.stop = POS_TENS;
        end
    end

    // drop requests that light nothing
    assign lit = entry.a.en | entry.b.en;

endmodule

@@ rtl/core/dsd_fifo.sv @@
// Short queue of classified requests between front and back.
module dsd_fifo
    import dsd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_data,
    output logic   full,
    input  logic   rd_en,
    output entry_t rd_data,
    output logic   rd_valid
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/core/dsd_back.sv @@
// Back end: peel one decimal digit a cycle while results are popped and drive the result register.
module dsd_back
    import dsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  entry_t     q_data,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] digit_pos,
    output logic [6:0] segments,
    output logic       last
);

    localparam int unsigned PROD_W = NUM_W + $bits(DIV10_RECIP);

    logic       active_reg, active_next;
    num_t       n_reg, n_next;
    logic [1:0] pos_reg, pos_next;
    logic [1:0] stop_reg, stop_next;
    logic       b_pend_reg, b_pend_next;
    run_t       b_reg, b_next;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_pos_reg, out_pos_next;
    logic [6:0] out_seg_reg, out_seg_next;
    logic       out_last_reg, out_last_next;

    logic [PROD_W-1:0] prod;
    num_t              quot;
    num_t              quot_x10;
    num_t              rem;
    logic              advance;
    logic              fire;
    logic              run_more;
    logic              job_done;
    logic              load;

    // divide by ten through the reciprocal, then recover the remainder
    assign prod     = PROD_W'(n_reg) * PROD_W'(DIV10_RECIP);
    assign quot     = NUM_W'(prod[PROD_W-1:DIV10_SHIFT]);
    assign quot_x10 = NUM_W'({quot, 3'b000}) + NUM_W'({quot, 1'b0});
    assign rem      = n_reg - quot_x10;

    assign advance  = !out_valid_reg || pop;
    assign fire     = active_reg && advance;
    assign run_more = (quot != '0) && (pos_reg != stop_reg);
    assign job_done = fire && !run_more && !b_pend_reg;
    assign load     = q_valid && (!active_reg || job_done);
    assign q_pop    = load;

    always_comb
    begin
        active_next = active_reg;
        n_next      = n_reg;
        pos_next    = pos_reg;
        stop_next   = stop_reg;
        b_pend_next = b_pend_reg;
        b_next      = b_reg;
        if (load)
        begin
            active_next = 1'b1;
            b_next      = q_data.b;
            if (q_data.a.en)
            begin
                n_next      = q_data.a.num;
                pos_next    = q_data.a.pos;
                stop_next   = q_data.a.stop;
                b_pend_next = q_data.b.en;
            end
            else
            begin
                n_next      = q_data.b.num;
                pos_next    = q_data.b.pos;
                stop_next   = q_data.b.stop;
                b_pend_next = 1'b0;
            end
        end
        else if (fire)
        begin
            if (run_more)
            begin
                n_next   = quot;
                pos_next = pos_reg - 1'b1;
            end
            else if (b_pend_reg)
            begin
                n_next      = b_reg.num;
                pos_next    = b_reg.pos;
                stop_next   = b_reg.stop;
                b_pend_next = 1'b0;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        out_seg_next   = out_seg_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = fire;
            out_pos_next   = pos_reg;
            out_seg_next   = seg_of(rem[3:0]);
            out_last_next  = !run_more && !b_pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            b_pend_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            b_pend_reg    <= b_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        pos_reg      <= pos_next;
        stop_reg     <= stop_next;
        b_reg        <= b_next;
        out_pos_reg  <= out_pos_next;
        out_seg_reg  <= out_seg_next;
        out_last_reg <= out_last_next;
    end

    assign empty     = !out_valid_reg;
    assign digit_pos = out_pos_reg;
    assign segments  = out_seg_reg;
    assign last      = out_last_reg;

endmodule

@@ rtl/core/decimal_seven_segment_digit_sequencer.sv @@
// A pushed item is queued, loaded into the digit engine, and its first digit registered for output.
// Throughput: one digit result per cycle, while results are popped, from the back end's shared
// divide-by-ten step; an item lights 1 to 4 digits, items that light nothing take no back-end time.
// The request queue (QUEUE_DEPTH entries) lets the front keep accepting while digits drain.
// Reset: rst_n clears the queue, the digit engine and the result register; no result is pending.
module decimal_seven_segment_digit_sequencer
    import dsd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        cmd,
    input  logic [15:0] value,
    input  logic [9:0]  x_dev,
    input  logic [9:0]  y_dev,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  digit_pos,
    output logic [6:0]  segments,
    output logic        last
);

    entry_t front_entry;
    logic   front_lit;
    logic   q_wr;
    entry_t q_data;
    logic   q_valid;
    logic   q_pop;

    dsd_front u_front (
        .cmd   (cmd),
        .value (value),
        .x_dev (x_dev),
        .y_dev (y_dev),
        .entry (front_entry),
        .lit   (front_lit)
    );

    assign q_wr = push && !full && front_lit;

    dsd_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_data  (front_entry),
        .full     (full),
        .rd_en    (q_pop),
        .rd_data  (q_data),
        .rd_valid (q_valid)
    );

    dsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .digit_pos (digit_pos),
        .segments  (segments),
        .last      (last)
    );

endmodule
